// ===== hdl/six_bit_color_packer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Six-bit color packer assertion macros
// Shorthand for the concurrent checks of the packer core, clocked on clk and
// quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIX_BIT_COLOR_PACKER_CORE_ASSERT_SVH
`define SIX_BIT_COLOR_PACKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPK_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cpk_pkg.sv =====
// ----------------------------------------------------------------------------
// Six-bit color packer package
// Shared types, constants and the single-value packing step.
// ----------------------------------------------------------------------------
`default_nettype none

package cpk_pkg;

	// Most results one transaction can cause.
	localparam int NUM_OUT = 3;

	// Keeps the top six bits of a channel.
	localparam logic [7:0] KEEP_MASK = 8'hFC;

	// Phase codes: where the pending bits stand in the packing or unpacking cycle.
	localparam logic [1:0] PH_EMPTY = 2'd0;
	localparam logic [1:0] PH_ONE   = 2'd1;
	localparam logic [1:0] PH_TWO   = 2'd2;
	localparam logic [1:0] PH_THREE = 2'd3;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_UNPACK_MODE = 2'd0,
		CFG_GREY_MODE   = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] packed_byte;
		logic       frame_last;
	} item_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] partial;
	} pack_state_t;

	// All results of one transaction, as loaded into the result buffer.
	typedef struct packed {
		logic [NUM_OUT-1:0][7:0] data;
		logic [1:0]              last_idx;
		logic                    frame_last;
	} batch_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic [1:0] phase;
		logic [7:0] partial;
	} pack_step_t;

	// Appends one six-bit value (top bits of v) to the pending bits.
	function automatic pack_step_t pack_step(input logic [1:0] phase,
		input logic [7:0] partial, input logic [7:0] v);
		pack_step_t r;
		logic [7:0] val;
		val = v & KEEP_MASK;
		r.emit = 1'b1;
		case (phase)
			PH_EMPTY: begin
				r.emit    = 1'b0;
				r.data    = '0;
				r.partial = val;
				r.phase   = PH_ONE;
			end
			PH_ONE: begin
				r.data    = partial | {6'd0, val[7:6]};
				r.partial = {val[5:0], 2'd0};
				r.phase   = PH_TWO;
			end
			PH_TWO: begin
				r.data    = partial | {4'd0, val[7:4]};
				r.partial = {val[3:0], 4'd0};
				r.phase   = PH_THREE;
			end
			default: begin
				r.data    = partial | {2'd0, val[7:2]};
				r.partial = '0;
				r.phase   = PH_EMPTY;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cpk_compute.sv =====
// ----------------------------------------------------------------------------
// Six-bit color packer datapath
// Turns one registered item and the held phase into its results and the next
// phase and partial byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cpk_compute (
	input  wire logic                 unpack_mode,
	input  wire logic                 grey_mode,
	input  wire cpk_pkg::item_t       item,
	input  wire cpk_pkg::pack_state_t state,
	output cpk_pkg::batch_t           batch,
	output cpk_pkg::pack_state_t      next_state
);

	// floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765.
	localparam logic [9:0] GREY_RECIP = 10'd683;
	localparam int         GREY_SHIFT = 11;

	logic [9:0]                       sum;
	logic [19:0]                      prod;
	logic [7:0]                       avg;
	logic [cpk_pkg::NUM_OUT-1:0][7:0] vals;
	cpk_pkg::pack_step_t              st;
	logic [1:0]                       n;
	logic [1:0]                       ph;
	logic [7:0]                       pt;
	logic [7:0]                       pb;

	assign sum  = {2'd0, item.red} + {2'd0, item.green} + {2'd0, item.blue};
	assign prod = {10'd0, sum} * {10'd0, GREY_RECIP};
	assign avg  = prod[GREY_SHIFT +: 8];
	assign pb   = item.packed_byte;

	always_comb begin
		if (grey_mode) begin
			vals = {avg, avg, avg};
		end else begin
			vals = {item.blue, item.green, item.red};
		end
		batch.data = '0;
		st         = '0;
		n          = '0;
		ph         = state.phase;
		pt         = state.partial;
		if (!unpack_mode) begin
			for (int i = 0; i < cpk_pkg::NUM_OUT; i++) begin
				st = cpk_pkg::pack_step(ph, pt, vals[i]);
				if (st.emit) begin
					batch.data[n] = st.data;
					n = n + 2'd1;
				end
				ph = st.phase;
				pt = st.partial;
			end
			// Pad and send out whatever is still pending at the end of a frame.
			if (item.frame_last && ph != cpk_pkg::PH_EMPTY) begin
				batch.data[n] = pt;
				n = n + 2'd1;
			end
		end else begin
			case (state.phase)
				cpk_pkg::PH_ONE: begin
					batch.data[0] = (state.partial | {2'd0, pb[7:2]}) & cpk_pkg::KEEP_MASK;
					pt = {pb[3:0], 4'd0};
					ph = cpk_pkg::PH_TWO;
					n  = 2'd1;
				end
				cpk_pkg::PH_TWO: begin
					batch.data[0] = (state.partial | {4'd0, pb[7:4]}) & cpk_pkg::KEEP_MASK;
					batch.data[1] = {pb[5:0], 2'd0};
					pt = '0;
					ph = cpk_pkg::PH_EMPTY;
					n  = 2'd2;
				end
				default: begin
					// A phase of three cannot come from unpacking; its bits are dropped.
					batch.data[0] = pb & cpk_pkg::KEEP_MASK;
					pt = {pb[1:0], 6'd0};
					ph = cpk_pkg::PH_ONE;
					n  = 2'd1;
				end
			endcase
		end
		if (item.frame_last) begin
			ph = cpk_pkg::PH_EMPTY;
			pt = '0;
		end
		batch.last_idx     = n - 2'd1;
		batch.frame_last   = item.frame_last;
		next_state.phase   = ph;
		next_state.partial = pt;
	end

endmodule

`default_nettype wire

// ===== hdl/cpk_result_buf.sv =====
// ----------------------------------------------------------------------------
// Six-bit color packer result buffer
// Holds the results of one item and hands them out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cpk_result_buf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire cpk_pkg::batch_t batch,
	output logic                 free,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 frame_done
);

	logic            valid_q;
	logic [1:0]      idx_q;
	cpk_pkg::batch_t batch_q;
	logic            take;
	logic            at_last;

	assign at_last    = idx_q == batch_q.last_idx;
	assign take       = valid_q && out_ready;
	assign free       = !valid_q || (take && at_last);
	assign out_valid  = valid_q;
	assign out_byte   = batch_q.data[idx_q];
	assign run_last   = at_last;
	assign frame_done = at_last && batch_q.frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			batch_q <= batch;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/six_bit_color_packer_core.sv =====
// ----------------------------------------------------------------------------
// Six-bit color packer core
// Packs RGB pixels into a stream of six-bit values, four to three bytes, or
// unpacks such a stream back into byte-aligned values.
// ----------------------------------------------------------------------------
// An item passes through the input register and then hands out its results one
// at a time on the one-byte output channel: a pixel gives two or three bytes,
// a packed byte one or two values. A long pixel frame averages two and a
// quarter bytes per pixel, since a pixel carries eighteen bits, plus one flush
// byte at a frame end with bits pending; an unpack stream gives four values
// for every three bytes. The output channel sets the pace; the datapath itself
// is combinational, and the next item moves into the result buffer in the
// same cycle in which the last result of the previous one is taken, so
// back-to-back items see no bubble. While results drain, the input register
// can already hold the following item. The mode registers may only be
// written while the core is idle; a write does not touch the held phase or
// partial byte.
`default_nettype none

`include "six_bit_color_packer_core_assert.svh"

module six_bit_color_packer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration write channel.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic       cfg_data,
	// Input item channel.
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] packed_byte,
	input  wire logic       frame_last,
	// Result channel.
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_done
);

	// Mode registers. They are always ready, since a write just loads the register.
	logic unpack_mode_q;
	logic grey_mode_q;

	// Input register stage and the packing state that carries across items.
	logic                 valid_s1;
	cpk_pkg::item_t       item_s1;
	cpk_pkg::pack_state_t state_q;

	cpk_pkg::batch_t      batch;
	cpk_pkg::pack_state_t next_state;
	logic                 buf_free;
	logic                 xfer;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unpack_mode_q <= 1'b0;
			grey_mode_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cpk_pkg::CFG_UNPACK_MODE: unpack_mode_q <= cfg_data;
				cpk_pkg::CFG_GREY_MODE:   grey_mode_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The registered item moves on when the result buffer is empty or is
	// handing out its final result in this cycle.
	assign xfer     = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.red         <= red;
			item_s1.green       <= green;
			item_s1.blue        <= blue;
			item_s1.packed_byte <= packed_byte;
			item_s1.frame_last  <= frame_last;
		end
	end

	// Phase and partial byte advance once per item, as it enters the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (xfer) begin
			state_q <= next_state;
		end
	end

	cpk_compute u_compute (
		.unpack_mode (unpack_mode_q),
		.grey_mode   (grey_mode_q),
		.item        (item_s1),
		.state       (state_q),
		.batch       (batch),
		.next_state  (next_state)
	);

	cpk_result_buf u_result_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (xfer),
		.batch      (batch),
		.free       (buf_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

	// A pixel always yields at least two bytes.
	`CPK_ASSERT_SAME(a_pack_count, xfer && !unpack_mode_q, batch.last_idx != 2'd0,
		"pixel gave fewer than two results")
	// A packed byte yields one or two values, never three.
	`CPK_ASSERT_SAME(a_unpack_count, xfer && unpack_mode_q, batch.last_idx != 2'd2,
		"packed byte gave three results")
	// An item moved into the buffer is presented on the next cycle.
	`CPK_ASSERT_NEXT(a_load_shows, xfer, out_valid, "loaded results not presented")

endmodule

`default_nettype wire

// ===== bench/six_bit_color_packer_core_test.sv =====
// ----------------------------------------------------------------------------
// Six-bit color packer core testbench
// Drives pixels and packed bytes through the core in every mode, and predicts
// each output byte with a behavioral copy of the packing and unpacking rules.
// A short table of hand-picked items comes first, then random frames, with
// random stalls on both channels and one long hold-off on the output.
// ----------------------------------------------------------------------------
module six_bit_color_packer_core_test;

	localparam int LIMIT     = 300000;
	localparam int LONG_HOLD = 200;
	localparam int TAIL      = 12;
	localparam int N_DIR     = 22;
	localparam int N_PHASES  = 6;
	localparam int PHASE_LEN = 16;

	// One row of the directed table. When n_typed is nonzero, the expected
	// bytes t0..t2 are taken as written instead of from the predictor.
	typedef struct packed {
		logic       unpack;
		logic       grey;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] pb;
		logic       last;
		logic [1:0] n_typed;
		logic [7:0] t0;
		logic [7:0] t1;
		logic [7:0] t2;
	} dir_row_t;

	// One byte due on the output channel.
	typedef struct {
		logic [7:0] data;
		logic       item_end;
		logic       frame_end;
	} out_beat_t;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// All-ones and all-zero pixels right after reset: three values, with the
		// trailing two bits flushed as a padded byte.
		'{0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1, 3, 8'hFF, 8'hFF, 8'hC0},
		'{0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 3, 8'h00, 8'h00, 8'h00},
		// A frame walking through every phase, ending where no flush is needed.
		'{0, 0, 8'h80, 8'h40, 8'h20, 8'h5A, 0, 0, 8'h00, 8'h00, 8'h00},
		'{0, 0, 8'h13, 8'h57, 8'h9B, 8'hA5, 0, 0, 8'h00, 8'h00, 8'h00},
		'{0, 0, 8'hC4, 8'h21, 8'h7E, 8'h0F, 0, 0, 8'h00, 8'h00, 8'h00},
		'{0, 0, 8'h3C, 8'hA5, 8'h5A, 8'hF0, 1, 0, 8'h00, 8'h00, 8'h00},
		// Low bits that must be masked off; leaves two bits pending.
		'{0, 0, 8'h01, 8'h02, 8'h03, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00},
		// Switch to unpack with pack bits pending: the odd phase is dropped.
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'hA7, 0, 0, 8'h00, 8'h00, 8'h00},
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 0, 8'h00, 8'h00, 8'h00},
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00},
		// End of frame in unpack mode drops the leftover padding.
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'h5C, 1, 0, 8'h00, 8'h00, 8'h00},
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 1, 1, 8'hFC, 8'h00, 8'h00},
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 8'h00, 8'h00, 8'h00},
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'h3E, 0, 0, 8'h00, 8'h00, 8'h00},
		'{1, 0, 8'h00, 8'h00, 8'h00, 8'h81, 1, 0, 8'h00, 8'h00, 8'h00},
		// Grey mode has no effect on unpacking.
		'{1, 1, 8'hFF, 8'h00, 8'h77, 8'hC3, 0, 0, 8'h00, 8'h00, 8'h00},
		// Back to packing with unpack bits held; grey averages round down.
		'{0, 1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00},
		'{0, 1, 8'h01, 8'h01, 8'h02, 8'h00, 1, 0, 8'h00, 8'h00, 8'h00},
		'{0, 1, 8'h00, 8'h00, 8'h00, 8'h00, 1, 3, 8'h00, 8'h00, 8'h00},
		'{0, 1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1, 3, 8'hFF, 8'hFF, 8'hC0},
		'{0, 1, 8'hFF, 8'h00, 8'h80, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00},
		'{0, 0, 8'h7F, 8'h80, 8'hFE, 8'h00, 1, 0, 8'h00, 8'h00, 8'h00}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] packed_byte;
	logic       frame_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_done;

	// Predictor copy of the mode registers and of the packing state.
	logic       unpack_on;
	logic       grey_on;
	logic [1:0] pk_phase;
	logic [7:0] pk_held;

	out_beat_t  due_bytes [$];
	int         mismatch_count;
	int         cycle_count;
	int         hold_left;
	bit         hold_req;
	bit         quiet_tail;

	six_bit_color_packer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.packed_byte (packed_byte),
		.frame_last  (frame_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.frame_done  (frame_done)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Appends one six-bit value to the pending bits, most significant first,
	// and emits a byte whenever eight bits are complete.
	function automatic void pack_six(input logic [7:0] v, inout int n,
		inout logic [2:0][7:0] res);
		logic [7:0] val;
		val = v & cpk_pkg::KEEP_MASK;
		case (pk_phase)
			cpk_pkg::PH_EMPTY: begin
				pk_held  = val;
				pk_phase = cpk_pkg::PH_ONE;
			end
			cpk_pkg::PH_ONE: begin
				res[n]   = pk_held | (val >> 6);
				n++;
				pk_held  = val << 2;
				pk_phase = cpk_pkg::PH_TWO;
			end
			cpk_pkg::PH_TWO: begin
				res[n]   = pk_held | (val >> 4);
				n++;
				pk_held  = val << 4;
				pk_phase = cpk_pkg::PH_THREE;
			end
			default: begin
				res[n]   = pk_held | (val >> 2);
				n++;
				pk_held  = '0;
				pk_phase = cpk_pkg::PH_EMPTY;
			end
		endcase
	endfunction

	// Works out the bytes one accepted transaction produces, in order, and
	// advances the predictor state. Returns how many there are.
	function automatic int predict_item(input cpk_pkg::item_t it,
		output logic [2:0][7:0] res);
		logic [9:0] sum;
		logic [7:0] c_r;
		logic [7:0] c_g;
		logic [7:0] c_b;
		int         n;
		n   = 0;
		res = '0;
		if (!unpack_on) begin
			c_r = it.red;
			c_g = it.green;
			c_b = it.blue;
			if (grey_on) begin
				sum = it.red + it.green + it.blue;
				c_r = sum / 3;
				c_g = c_r;
				c_b = c_r;
			end
			pack_six(c_r, n, res);
			pack_six(c_g, n, res);
			pack_six(c_b, n, res);
			// Frame end with bits pending: flush them, zero padded.
			if (it.frame_last && pk_phase != cpk_pkg::PH_EMPTY) begin
				res[n] = pk_held;
				n++;
			end
		end else begin
			case (pk_phase)
				cpk_pkg::PH_ONE: begin
					res[0]   = (pk_held | (it.packed_byte >> 2)) & cpk_pkg::KEEP_MASK;
					n        = 1;
					pk_held  = it.packed_byte << 4;
					pk_phase = cpk_pkg::PH_TWO;
				end
				cpk_pkg::PH_TWO: begin
					res[0]   = (pk_held | (it.packed_byte >> 4)) & cpk_pkg::KEEP_MASK;
					res[1]   = it.packed_byte << 2;
					n        = 2;
					pk_held  = '0;
					pk_phase = cpk_pkg::PH_EMPTY;
				end
				// Empty, and the odd leftover phase from packing, start afresh.
				default: begin
					res[0]   = it.packed_byte & cpk_pkg::KEEP_MASK;
					n        = 1;
					pk_held  = it.packed_byte << 6;
					pk_phase = cpk_pkg::PH_ONE;
				end
			endcase
		end
		if (it.frame_last) begin
			pk_phase = cpk_pkg::PH_EMPTY;
			pk_held  = '0;
		end
		return n;
	endfunction

	function automatic logic [7:0] rand_level();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Offers one transaction and holds it until accepted. The expected bytes
	// are queued at the accepting edge, so they are always ahead of the output.
	task automatic send_item(input cpk_pkg::item_t it, input logic [1:0] n_typed,
		input logic [2:0][7:0] typed);
		logic [2:0][7:0] res;
		int              n;
		out_beat_t       beat;
		@(negedge clk);
		in_valid    <= 1'b1;
		red         <= it.red;
		green       <= it.green;
		blue        <= it.blue;
		packed_byte <= it.packed_byte;
		frame_last  <= it.frame_last;
		do @(posedge clk); while (!in_ready);
		n = predict_item(it, res);
		if (n_typed != 0) begin
			n   = n_typed;
			res = typed;
		end
		for (int i = 0; i < n; i++) begin
			beat.data      = res[i];
			beat.item_end  = (i == n - 1);
			beat.frame_end = (i == n - 1) && it.frame_last;
			due_bytes      = {due_bytes, beat};
		end
	endtask

	// Drops valid for a burst of cycles, unless idling is off at the moment.
	// During the long output hold-off the sender keeps offering, so that the
	// core fills up and has to stall its input.
	task automatic maybe_idle();
		int gap;
		if (!quiet_tail && !hold_req && hold_left == 0 && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input cpk_pkg::cfg_index_t idx, input logic d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			cpk_pkg::CFG_UNPACK_MODE: unpack_on = d;
			default: grey_on = d;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mode registers are only written once every queued byte has come out. Every
	// transaction yields at least one byte, so an empty queue means the core
	// holds no work.
	task automatic set_modes(input logic u, input logic g);
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		write_reg(cpk_pkg::CFG_UNPACK_MODE, u);
		write_reg(cpk_pkg::CFG_GREY_MODE, g);
	endtask

	// Compare every output transaction against the oldest queued byte.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_bytes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected byte %h (run_last %b, frame_done %b)",
					$time, out_byte, run_last, frame_done);
			end else begin
				want = due_bytes.pop_front();
				check_field("out_byte", want.data, out_byte);
				check_field("run_last", want.item_end, run_last);
				check_field("frame_done", want.frame_end, frame_done);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Output side: random bursts of back-pressure, one long hold-off when asked,
	// and a steady ready in the quiet tail of the run.
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req  = 1'b0;
				out_ready <= 1'b0;
				hold_left = LONG_HOLD;
				while (hold_left > 0) begin
					@(negedge clk);
					hold_left--;
				end
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	initial begin
		cpk_pkg::item_t it;
		dir_row_t       row;
		int             left_in_frame;
		logic           u;
		logic           g;

		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = cpk_pkg::CFG_UNPACK_MODE;
		cfg_data       = 1'b0;
		in_valid       = 1'b0;
		red            = '0;
		green          = '0;
		blue           = '0;
		packed_byte    = '0;
		frame_last     = 1'b0;
		unpack_on      = 1'b0;
		grey_on        = 1'b0;
		pk_phase       = cpk_pkg::PH_EMPTY;
		pk_held        = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		hold_req       = 1'b0;
		quiet_tail     = 1'b0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table. The first rows run on the reset modes; later rows
		// change mode with bits still pending, which the core must keep.
		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			if (row.unpack != unpack_on || row.grey != grey_on)
				set_modes(row.unpack, row.grey);
			maybe_idle();
			it.red         = row.r;
			it.green       = row.g;
			it.blue        = row.b;
			it.packed_byte = row.pb;
			it.frame_last  = row.last;
			send_item(it, row.n_typed, {row.t2, row.t1, row.t0});
		end

		// Random frames of one to eight items. Now and then frame_last is set at
		// random, which cuts a frame short or lets it run on, and a phase may
		// end inside a frame so the next mode inherits its pending bits.
		for (int p = 0; p < N_PHASES; p++) begin
			quiet_tail = (p == N_PHASES - 1);
			u = (p < 4) ? p[1] : $urandom_range(0, 1);
			g = (p < 4) ? p[0] : $urandom_range(0, 1);
			set_modes(u, g);
			if (p == 0)
				hold_req = 1'b1;
			left_in_frame = $urandom_range(1, 8);
			repeat (PHASE_LEN) begin
				maybe_idle();
				it.red         = rand_level();
				it.green       = rand_level();
				it.blue        = rand_level();
				it.packed_byte = rand_level();
				it.frame_last  = (left_in_frame == 1);
				if ($urandom_range(0, 7) == 0)
					it.frame_last = $urandom_range(0, 1);
				if (it.frame_last || left_in_frame <= 1)
					left_in_frame = $urandom_range(1, 8);
				else
					left_in_frame--;
				send_item(it, 2'd0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cpk_pkg.sv
hdl/cpk_compute.sv
hdl/cpk_result_buf.sv
hdl/six_bit_color_packer_core.sv
bench/six_bit_color_packer_core_test.sv
